// ===== sv/pftr_pkg.sv =====
`timescale 1ns / 1ps

package pftr_pkg;

   // Item actions
   localparam logic [1:0] ACT_CLEAR  = 2'd0;
   localparam logic [1:0] ACT_RENDER = 2'd1;
   localparam logic [1:0] ACT_READ   = 2'd2;
   localparam logic [1:0] ACT_NONE   = 2'd3;

   // Register indexes
   localparam logic CSR_IMAGE_WIDTH   = 1'b0;
   localparam logic CSR_INITIAL_PAGES = 1'b1;

   // Widest store address over the parameter range (255 x 32 bytes)
   localparam int STORE_AW_MAX = 13;
   // Address sums before the range check (column + width * page + width)
   localparam int CALC_W = 14;

   // Glyph numbers and character codes
   localparam logic [4:0] GLYPH_BLANK    = 5'd26;
   localparam logic [4:0] GLYPH_PERIOD   = 5'd27;
   localparam logic [4:0] GLYPH_QUESTION = 5'd28;
   localparam logic [4:0] GLYPH_EXCLAIM  = 5'd29;
   localparam logic [4:0] GLYPH_COMMA    = 5'd30;

   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_Z = 8'h5A;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_LOWER_Z = 8'h7A;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_PERIOD  = 8'h2E;
   localparam logic [7:0] CH_QUESTION = 8'h3F;
   localparam logic [7:0] CH_EXCLAIM = 8'h21;
   localparam logic [7:0] CH_COMMA   = 8'h2C;

   // 5-row font, pixel rows in bits 7..3; last slot unused
   localparam logic [7:0] FONT_ROM [32][4] = '{
      '{8'hF0, 8'h48, 8'h48, 8'hF0}, '{8'hF8, 8'hA8, 8'hA8, 8'h50},
      '{8'h70, 8'h88, 8'h88, 8'h50}, '{8'hF8, 8'h88, 8'h88, 8'h70},
      '{8'hF8, 8'hA8, 8'hA8, 8'h88}, '{8'hF8, 8'h28, 8'h28, 8'h08},
      '{8'h70, 8'h88, 8'hA8, 8'hE8}, '{8'hF8, 8'h20, 8'h20, 8'hF8},
      '{8'h88, 8'hF8, 8'h88, 8'h00}, '{8'h88, 8'h88, 8'h88, 8'h78},
      '{8'hF8, 8'h20, 8'h50, 8'h88}, '{8'hF8, 8'h80, 8'h80, 8'h00},
      '{8'hF8, 8'h10, 8'h10, 8'hF8}, '{8'hF8, 8'h10, 8'h20, 8'hF8},
      '{8'h70, 8'h88, 8'h88, 8'h70}, '{8'hF8, 8'h48, 8'h48, 8'h30},
      '{8'h70, 8'h88, 8'h48, 8'hB0}, '{8'hF8, 8'h48, 8'h48, 8'hB0},
      '{8'h90, 8'hA8, 8'hA8, 8'h48}, '{8'h08, 8'hF8, 8'h08, 8'h00},
      '{8'h78, 8'h80, 8'h80, 8'h78}, '{8'h78, 8'h80, 8'h60, 8'h18},
      '{8'hF8, 8'h40, 8'h40, 8'hF8}, '{8'hD8, 8'h20, 8'h20, 8'hD8},
      '{8'h98, 8'hA0, 8'hA0, 8'h78}, '{8'hC8, 8'hA8, 8'hA8, 8'h98},
      '{8'h00, 8'h00, 8'h00, 8'h00}, '{8'h80, 8'h00, 8'h00, 8'h00},
      '{8'h10, 8'h08, 8'hA8, 8'h10}, '{8'hB8, 8'h00, 8'h00, 8'h00},
      '{8'hC0, 8'h00, 8'h00, 8'h00}, '{8'h00, 8'h00, 8'h00, 8'h00}
   };

   typedef struct packed {
      logic                    en;
      logic                    we;
      logic [STORE_AW_MAX-1:0] addr;
      logic [7:0]              wdata;
   } mem_req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic [7:0] cursor_column;
      logic [7:0] cursor_row;
      logic [3:0] page_count;
      logic       overflow;
   } result_type;

   typedef struct packed {
      logic       supported;
      logic       space;
      logic [4:0] glyph;
   } glyph_sel_type;

   // Columns before the first empty one
   function automatic logic [2:0] glyph_width(input logic [4:0] g);
      logic [2:0] w;
      logic       stop;
      w    = '0;
      stop = 1'b0;
      for (int i = 0; i < 4; i++) begin
         if (!stop && FONT_ROM[g][i] != 8'h00) begin
            w = w + 3'd1;
         end else begin
            stop = 1'b1;
         end
      end
      return w;
   endfunction

   function automatic glyph_sel_type char_to_glyph(input logic [7:0] ch);
      glyph_sel_type s;
      s = '{supported: 1'b1, space: 1'b0, glyph: GLYPH_BLANK};
      priority if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) begin
         s.glyph = 5'(ch - CH_UPPER_A);
      end else if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z) begin
         s.glyph = 5'(ch - CH_LOWER_A);
      end else if (ch == CH_SPACE) begin
         s.space = 1'b1;
      end else if (ch == CH_PERIOD) begin
         s.glyph = GLYPH_PERIOD;
      end else if (ch == CH_QUESTION) begin
         s.glyph = GLYPH_QUESTION;
      end else if (ch == CH_EXCLAIM) begin
         s.glyph = GLYPH_EXCLAIM;
      end else if (ch == CH_COMMA) begin
         s.glyph = GLYPH_COMMA;
      end else begin
         s.supported = 1'b0;
      end
      return s;
   endfunction

endpackage

// ===== sv/page_framebuffer_text_renderer_top.sv =====
`timescale 1ns / 1ps

// Page-organised text renderer: one item per request, one result item back.
// Request channel (req_*): action 0 clears the framebuffer and cursor, 1 draws
// req_char_code at the cursor, 2 reads the byte at req_read_address, 3 only
// reports. Result (rsp_*): read byte, cursor column/row, page count and an
// overflow flag for writes that fell outside the store.
// Config (csr_*): index 0 image width, index 1 page count loaded on clear;
// always ready, write only while no item is in flight.
// Steps: a render passes wrap and base, then per byte touched (up to 8) a read
// and an OR write-back in the single-port store (none past the store), then
// advance; a space draws the blank glyph twice; a skipped code or action 3 goes
// to done; a read captures the byte; a clear zeroes the store. The result item
// goes valid in the same cycle that the next item can first be taken.
// One item at a time; the next item is taken while the result still waits.
// Reset: cursor to 0,0, one page, registers to width 128 / one page, then a
// clearing pass over all MAX_WIDTH*MAX_PAGES bytes with req_stall high.
// A stalled result holds in the output register; the sequencer waits in its
// done state until that register is free.
module page_framebuffer_text_renderer_top
   import pftr_pkg::*;
#(
   parameter int MAX_WIDTH = 128,
   parameter int MAX_PAGES = 8
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_action,
   input  logic [7:0] req_char_code,
   input  logic [9:0] req_read_address,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_read_data,
   output logic [7:0] rsp_cursor_column,
   output logic [7:0] rsp_cursor_row,
   output logic [3:0] rsp_page_count,
   output logic       rsp_overflow,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_index,
   input  logic [7:0] csr_wdata
);

   localparam int DEPTH = MAX_WIDTH * MAX_PAGES;
   localparam int AW    = $clog2(DEPTH);
   localparam int PW    = $clog2(MAX_PAGES + 1);

   logic [7:0]  image_width_ff;
   logic [3:0]  initial_pages_ff;
   logic        rsp_valid_ff;
   result_type  rsp_ff;
   logic        slot_free;
   logic        done;
   result_type  result;
   mem_req_type mem_req;
   logic [7:0]  mem_rdata;

   // Register file: plain writes, no side effects
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff   <= 8'd128;
         initial_pages_ff <= 4'd1;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:   image_width_ff   <= csr_wdata;
            CSR_INITIAL_PAGES: initial_pages_ff <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   // Output register
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (done) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_read_data     = rsp_ff.read_data;
   assign rsp_cursor_column = rsp_ff.cursor_column;
   assign rsp_cursor_row    = rsp_ff.cursor_row;
   assign rsp_page_count    = rsp_ff.page_count;
   assign rsp_overflow      = rsp_ff.overflow;

   pftr_seq #(
      .MAX_PAGES (MAX_PAGES),
      .DEPTH     (DEPTH),
      .AW        (AW),
      .PW        (PW)
   ) u_seq (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_char_code    (req_char_code),
      .req_read_address (req_read_address),
      .image_width      (image_width_ff),
      .initial_pages    (initial_pages_ff),
      .slot_free        (slot_free),
      .done             (done),
      .result           (result),
      .mem_req          (mem_req),
      .mem_rdata        (mem_rdata)
   );

   pftr_store #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_store (
      .clock     (clock),
      .mem_req   (mem_req),
      .mem_rdata (mem_rdata)
   );

endmodule

// ===== sv/pftr_store.sv =====
`timescale 1ns / 1ps

module pftr_store
   import pftr_pkg::*;
#(
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  logic        clock,
   input  mem_req_type mem_req,
   output logic [7:0]  mem_rdata
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (mem_req.en) begin
         if (mem_req.we) begin
            mem[mem_req.addr[AW-1:0]] <= mem_req.wdata;
         end else begin
            rdata_ff <= mem[mem_req.addr[AW-1:0]];
         end
      end
   end

   assign mem_rdata = rdata_ff;

endmodule

// ===== sv/pftr_seq.sv =====
`timescale 1ns / 1ps

module pftr_seq
   import pftr_pkg::*;
#(
   parameter int MAX_PAGES = 8,
   parameter int DEPTH     = 1024,
   parameter int AW        = 10,
   parameter int PW        = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_action,
   input  logic [7:0]  req_char_code,
   input  logic [9:0]  req_read_address,
   input  logic [7:0]  image_width,
   input  logic [3:0]  initial_pages,
   input  logic        slot_free,
   output logic        done,
   output result_type  result,
   output mem_req_type mem_req,
   input  logic [7:0]  mem_rdata
);

   typedef enum logic [8:0] {
      ST_CLEAR = 9'b000000001,
      ST_IDLE  = 9'b000000010,
      ST_WRAP  = 9'b000000100,
      ST_BASE  = 9'b000001000,
      ST_RD    = 9'b000010000,
      ST_WR    = 9'b000100000,
      ST_ADV   = 9'b001000000,
      ST_RDCAP = 9'b010000000,
      ST_DONE  = 9'b100000000
   } state_type;

   state_type         state_ff, state_in;
   logic [7:0]        cur_left_ff, cur_left_in;
   logic [7:0]        cur_top_ff, cur_top_in;
   logic [PW-1:0]     pages_ff, pages_in;
   logic [4:0]        glyph_ff, glyph_in;
   logic              repeat_ff, repeat_in;
   logic [2:0]        width_ff, width_in;
   logic [1:0]        col_ff, col_in;
   logic              lower_ff, lower_in;
   logic [CALC_W-1:0] base_ff, base_in;
   logic              ovf_ff, ovf_in;
   logic [7:0]        rd_ff, rd_in;
   logic [AW-1:0]     clr_idx_ff, clr_idx_in;
   logic              clr_rsp_ff, clr_rsp_in;

   logic              req_accept;
   glyph_sel_type     sel;
   logic [2:0]        w_cur;
   logic              wrap;
   logic [7:0]        top_wrapped;
   logic              grow;
   logic [CALC_W-1:0] addr_calc;
   logic              addr_ok;
   logic [15:0]       shifted;
   logic [7:0]        bits;
   logic              more_cols;
   logic              need_lower;
   logic [12:0]       page_off;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign sel        = char_to_glyph(req_char_code);
   assign w_cur      = glyph_width(glyph_ff);

   // Wrap test and page growth against the wrapped row
   assign wrap        = ({1'b0, cur_left_ff} + 9'(w_cur)) >= {1'b0, image_width};
   assign top_wrapped = cur_top_ff + 8'd6;
   assign grow        = (({2'b0, top_wrapped} + 10'd5) > (10'(pages_ff) << 3))
                        && (32'(pages_ff) < MAX_PAGES);

   assign page_off  = 13'(image_width) * 13'(cur_top_ff[7:3]);
   assign addr_calc = base_ff + CALC_W'(col_ff)
                      + (lower_ff ? CALC_W'(image_width) : CALC_W'(0));
   assign addr_ok   = addr_calc < CALC_W'(DEPTH);

   // Glyph column placed at the row offset; upper page bits 10:3, lower 15:11
   assign shifted = 16'(FONT_ROM[glyph_ff][col_ff]) << cur_top_ff[2:0];
   assign bits    = lower_ff ? {3'b000, shifted[15:11]} : shifted[10:3];

   assign more_cols  = (3'(col_ff) + 3'd1) < width_ff;
   assign need_lower = !lower_ff && (cur_top_ff[2:0] > 3'd3);

   always_comb begin
      state_in    = state_ff;
      cur_left_in = cur_left_ff;
      cur_top_in  = cur_top_ff;
      pages_in    = pages_ff;
      glyph_in    = glyph_ff;
      repeat_in   = repeat_ff;
      width_in    = width_ff;
      col_in      = col_ff;
      lower_in    = lower_ff;
      base_in     = base_ff;
      ovf_in      = ovf_ff;
      rd_in       = rd_ff;
      clr_idx_in  = clr_idx_ff;
      clr_rsp_in  = clr_rsp_ff;
      mem_req     = '{en: 1'b0, we: 1'b0, addr: '0, wdata: '0};
      done        = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            mem_req = '{en: 1'b1, we: 1'b1, addr: STORE_AW_MAX'(clr_idx_ff), wdata: 8'h00};
            clr_idx_in = clr_idx_ff + AW'(1);
            if (clr_idx_ff == AW'(DEPTH - 1)) begin
               state_in = clr_rsp_ff ? ST_DONE : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               ovf_in = 1'b0;
               rd_in  = 8'h00;
               unique case (req_action)
                  ACT_CLEAR: begin
                     cur_left_in = '0;
                     cur_top_in  = '0;
                     pages_in    = (32'(initial_pages) > MAX_PAGES) ? PW'(MAX_PAGES)
                                                                    : PW'(initial_pages);
                     clr_idx_in  = '0;
                     clr_rsp_in  = 1'b1;
                     state_in    = ST_CLEAR;
                  end
                  ACT_RENDER: begin
                     glyph_in  = sel.glyph;
                     repeat_in = sel.space;
                     state_in  = sel.supported ? ST_WRAP : ST_DONE;
                  end
                  ACT_READ: begin
                     if (32'(req_read_address) < DEPTH) begin
                        mem_req = '{en: 1'b1, we: 1'b0,
                                    addr: STORE_AW_MAX'(req_read_address), wdata: 8'h00};
                        state_in = ST_RDCAP;
                     end else begin
                        state_in = ST_DONE;
                     end
                  end
                  ACT_NONE: begin
                     state_in = ST_DONE;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_WRAP: begin
            if (wrap) begin
               cur_left_in = '0;
               cur_top_in  = top_wrapped;
               if (grow) begin
                  pages_in = pages_ff + PW'(1);
               end
            end
            width_in = w_cur;
            col_in   = '0;
            lower_in = 1'b0;
            state_in = ST_BASE;
         end
         ST_BASE: begin
            base_in  = CALC_W'(cur_left_ff) + CALC_W'(page_off);
            state_in = (width_ff == 3'd0) ? ST_ADV : ST_RD;
         end
         ST_RD, ST_WR: begin
            if (state_ff == ST_RD && addr_ok) begin
               mem_req  = '{en: 1'b1, we: 1'b0, addr: STORE_AW_MAX'(addr_calc), wdata: 8'h00};
               state_in = ST_WR;
            end else begin
               if (state_ff == ST_WR) begin
                  mem_req = '{en: 1'b1, we: 1'b1, addr: STORE_AW_MAX'(addr_calc),
                              wdata: mem_rdata | bits};
               end else begin
                  ovf_in = 1'b1;
               end
               priority if (more_cols) begin
                  col_in   = col_ff + 2'd1;
                  state_in = ST_RD;
               end else if (need_lower) begin
                  col_in   = '0;
                  lower_in = 1'b1;
                  state_in = ST_RD;
               end else begin
                  state_in = ST_ADV;
               end
            end
         end
         ST_ADV: begin
            cur_left_in = cur_left_ff + 8'(width_ff) + 8'd1;
            if (repeat_ff) begin
               repeat_in = 1'b0;
               state_in  = ST_WRAP;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_RDCAP: begin
            rd_in    = mem_rdata;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (slot_free) begin
               done     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign result = '{read_data: rd_ff, cursor_column: cur_left_ff, cursor_row: cur_top_ff,
                     page_count: 4'(pages_ff), overflow: ovf_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         cur_left_ff <= '0;
         cur_top_ff  <= '0;
         pages_ff    <= PW'(1);
         repeat_ff   <= 1'b0;
         clr_idx_ff  <= '0;
         clr_rsp_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         cur_left_ff <= cur_left_in;
         cur_top_ff  <= cur_top_in;
         pages_ff    <= pages_in;
         repeat_ff   <= repeat_in;
         clr_idx_ff  <= clr_idx_in;
         clr_rsp_ff  <= clr_rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      glyph_ff <= glyph_in;
      width_ff <= width_in;
      col_ff   <= col_in;
      lower_ff <= lower_in;
      base_ff  <= base_in;
      ovf_ff   <= ovf_in;
      rd_ff    <= rd_in;
   end

`ifndef SYNTHESIS
   a_write_in_store: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WR |-> addr_calc < CALC_W'(DEPTH))
      else $error("glyph write-back outside the store");

   a_pages_saturate: assert property (@(posedge clock) disable iff (reset)
      32'(pages_ff) <= MAX_PAGES)
      else $error("page count above its limit");

   a_clear_cursor: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_action == ACT_CLEAR |=> cur_left_ff == '0 && cur_top_ff == '0)
      else $error("clear left the cursor in place");

   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE && !req_accept |-> !mem_req.en)
      else $error("store access while idle");
`endif

endmodule

// ===== tb/pftr_result_check.sv =====
`timescale 1ns / 1ps

// Watches the request, result and register channels of the text renderer,
// keeps its own copy of the framebuffer and cursor, and compares every result
// item with the prediction for the oldest item still in flight.
module pftr_result_check
   import pftr_pkg::*;
#(
   parameter int MAX_WIDTH = 128,
   parameter int MAX_PAGES = 8
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [1:0] req_action,
   input  logic [7:0] req_char_code,
   input  logic [9:0] req_read_address,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic [7:0] rsp_read_data,
   input  logic [7:0] rsp_cursor_column,
   input  logic [7:0] rsp_cursor_row,
   input  logic [3:0] rsp_page_count,
   input  logic       rsp_overflow,
   input  logic       csr_valid,
   input  logic       csr_ready,
   input  logic       csr_index,
   input  logic [7:0] csr_wdata,
   output int         fail_count,
   output int         pending_count
);

   localparam int STORE_BYTES = MAX_WIDTH * MAX_PAGES;

   logic [7:0] frame_bytes [STORE_BYTES];
   logic [7:0] cursor_x;
   logic [7:0] cursor_y;
   int         pages_used;
   logic [7:0] image_width;
   logic [3:0] clear_pages;
   result_type report_q [$];

   function automatic logic or_into_frame(input int addr, input logic [7:0] bits);
      if (addr >= STORE_BYTES) begin
         return 1'b1;
      end
      frame_bytes[addr] = frame_bytes[addr] | bits;
      return 1'b0;
   endfunction

   // Draws one glyph at the cursor; returns 1 if a byte fell past the store.
   function automatic logic draw_glyph(input logic [4:0] g);
      int         w;
      int         row_page;
      int         row_shift;
      int         base;
      logic [7:0] col;
      logic       spill;
      w     = 0;
      spill = 1'b0;
      while (w < 4 && FONT_ROM[g][w] != 8'h00) w++;
      if (int'(cursor_x) + w >= int'(image_width)) begin
         cursor_x = 8'd0;
         cursor_y = cursor_y + 8'd6;
         if (int'(cursor_y) + 5 > 8 * pages_used && pages_used < MAX_PAGES) begin
            pages_used++;
         end
      end
      row_page  = int'(cursor_y[7:3]);
      row_shift = int'(cursor_y[2:0]);
      base      = int'(cursor_x) + int'(image_width) * row_page;
      // glyph rows live in bits 7..3; line them up with the cursor row
      for (int i = 0; i < w; i++) begin
         col = FONT_ROM[g][i];
         if (row_shift <= 3) begin
            spill |= or_into_frame(base + i, col >> (3 - row_shift));
         end else begin
            spill |= or_into_frame(base + i, col << (row_shift - 3));
         end
      end
      // lower rows spill into the next page
      if (row_shift > 3) begin
         for (int i = 0; i < w; i++) begin
            col = FONT_ROM[g][i];
            spill |= or_into_frame(base + int'(image_width) + i, col >> (11 - row_shift));
         end
      end
      cursor_x = cursor_x + 8'(w + 1);
      return spill;
   endfunction

   function automatic result_type predict_result(input logic [1:0] act, input logic [7:0] ch,
                                                 input logic [9:0] addr);
      result_type r;
      logic       spill;
      r     = '0;
      spill = 1'b0;
      case (act)
         ACT_CLEAR: begin
            for (int i = 0; i < STORE_BYTES; i++) frame_bytes[i] = 8'h00;
            cursor_x   = 8'd0;
            cursor_y   = 8'd0;
            pages_used = (int'(clear_pages) > MAX_PAGES) ? MAX_PAGES : int'(clear_pages);
         end
         ACT_RENDER: begin
            if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) begin
               spill = draw_glyph(5'(ch - CH_UPPER_A));
            end else if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z) begin
               spill = draw_glyph(5'(ch - CH_LOWER_A));
            end else if (ch == CH_SPACE) begin
               spill = draw_glyph(GLYPH_BLANK);
               spill |= draw_glyph(GLYPH_BLANK);
            end else if (ch == CH_PERIOD) begin
               spill = draw_glyph(GLYPH_PERIOD);
            end else if (ch == CH_QUESTION) begin
               spill = draw_glyph(GLYPH_QUESTION);
            end else if (ch == CH_EXCLAIM) begin
               spill = draw_glyph(GLYPH_EXCLAIM);
            end else if (ch == CH_COMMA) begin
               spill = draw_glyph(GLYPH_COMMA);
            end
         end
         ACT_READ: begin
            if (int'(addr) < STORE_BYTES) r.read_data = frame_bytes[addr];
         end
         default: ;
      endcase
      r.cursor_column = cursor_x;
      r.cursor_row    = cursor_y;
      r.page_count    = 4'(pages_used);
      r.overflow      = spill;
      return r;
   endfunction

   function automatic void check_field(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         for (int i = 0; i < STORE_BYTES; i++) frame_bytes[i] = 8'h00;
         cursor_x    = 8'd0;
         cursor_y    = 8'd0;
         pages_used  = 1;
         image_width = 8'd128;
         clear_pages = 4'd1;
         report_q.delete();
         fail_count  = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (report_q.size() == 0) begin
               $error("result item with nothing in flight");
               fail_count++;
            end else begin
               want = report_q.pop_front();
               check_field("read_data", want.read_data, rsp_read_data);
               check_field("cursor_column", want.cursor_column, rsp_cursor_column);
               check_field("cursor_row", want.cursor_row, rsp_cursor_row);
               check_field("page_count", 8'(want.page_count), 8'(rsp_page_count));
               check_field("overflow", 8'(want.overflow), 8'(rsp_overflow));
            end
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_IMAGE_WIDTH) begin
               image_width = csr_wdata;
            end else begin
               clear_pages = csr_wdata[3:0];
            end
         end
         if (req_valid && !req_stall) begin
            report_q.push_back(predict_result(req_action, req_char_code, req_read_address));
         end
      end
      pending_count <= report_q.size();
   end

endmodule

// ===== tb/tb_page_framebuffer_text_renderer_top.sv =====
`timescale 1ns / 1ps

module tb_page_framebuffer_text_renderer_top;
   import pftr_pkg::*;

   localparam int MAX_WIDTH        = 128;
   localparam int MAX_PAGES        = 8;
   localparam int ITEM_TARGET      = 1850;
   localparam int QUIET_TAIL       = 150;  // last items run with no idling
   localparam int LONG_HOLD_AT     = 400;  // item count that triggers the long rsp hold
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int DRAIN_CYCLES     = 40;   // wait after draining for a stray result

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [1:0] req_action = ACT_NONE;
   logic [7:0] req_char_code = 8'h00;
   logic [9:0] req_read_address = 10'd0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_read_data;
   logic [7:0] rsp_cursor_column;
   logic [7:0] rsp_cursor_row;
   logic [3:0] rsp_page_count;
   logic       rsp_overflow;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic       csr_index = CSR_IMAGE_WIDTH;
   logic [7:0] csr_wdata = 8'h00;

   int fail_count;
   int pending_count;
   int items_sent = 0;  // accepted items that the block acts on
   bit gappy = 1'b0;    // sender idles in this phase
   bit quiet = 1'b0;    // tail of the run: no idling on either side

   always #5 clock = ~clock;

   page_framebuffer_text_renderer_top #(
      .MAX_WIDTH(MAX_WIDTH),
      .MAX_PAGES(MAX_PAGES)
   ) DUT (.*);

   pftr_result_check #(
      .MAX_WIDTH(MAX_WIDTH),
      .MAX_PAGES(MAX_PAGES)
   ) u_render_check (.*);

   // Present one item and hold it until the block takes it. A gap, when
   // drawn, drops valid first; valid otherwise stays high back to back.
   task automatic offer_item(input logic [1:0] act, input logic [7:0] ch,
                             input logic [9:0] addr, input bit counted);
      if (gappy && !quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_action       <= act;
      req_char_code    <= ch;
      req_read_address <= addr;
      do @(posedge clock); while (req_stall);
      if (counted) items_sent++;
   endtask

   // Stop sending and wait until every predicted result has come back.
   // pending_count is registered, hence the wait before the first look.
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   // Register writes back to back; valid stays up between the two.
   task automatic write_regs(input bit set_width, input logic [7:0] width_val,
                             input bit set_pages, input logic [7:0] pages_val);
      if (set_width) begin
         csr_valid <= 1'b1;
         csr_index <= CSR_IMAGE_WIDTH;
         csr_wdata <= width_val;
         do @(posedge clock); while (!csr_ready);
      end
      if (set_pages) begin
         csr_valid <= 1'b1;
         csr_index <= CSR_INITIAL_PAGES;
         csr_wdata <= pages_val;
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
   endtask

   // Result side: random stall bursts, calm stretches, and one long hold
   // while the sender keeps offering, so the block backs up and stalls req.
   initial begin
      bit hold_done;
      hold_done = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (!hold_done && items_sent >= LONG_HOLD_AT && req_valid) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            hold_done = 1'b1;
         end else if (!quiet && $urandom_range(0, 2) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 60)) @(posedge clock);
         end
      end
   end

   initial begin
      int         phase_len;
      int         pick;
      logic [7:0] ch;
      logic [9:0] addr;
      logic [7:0] width_val;
      logic [7:0] pages_val;
      bit         first_phase;
      bit         tidy;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: a read of the blank store, the idle action, the ends of both
      // letter ranges, every punctuation mark and the space, then codes just
      // outside the letter ranges, the extremes of the code field and two reads.
      offer_item(ACT_READ, 8'h00, 10'd0, 1'b1);
      offer_item(ACT_NONE, 8'hFF, 10'h3FF, 1'b1);
      offer_item(ACT_RENDER, CH_UPPER_A, 10'd0, 1'b1);
      offer_item(ACT_RENDER, CH_UPPER_Z, 10'd0, 1'b1);
      offer_item(ACT_RENDER, CH_LOWER_A, 10'd0, 1'b1);
      offer_item(ACT_RENDER, CH_LOWER_Z, 10'd0, 1'b1);
      offer_item(ACT_RENDER, CH_SPACE, 10'd0, 1'b1);
      offer_item(ACT_RENDER, CH_PERIOD, 10'd0, 1'b1);
      offer_item(ACT_RENDER, CH_QUESTION, 10'd0, 1'b1);
      offer_item(ACT_RENDER, CH_EXCLAIM, 10'd0, 1'b1);
      offer_item(ACT_RENDER, CH_COMMA, 10'd0, 1'b1);
      offer_item(ACT_RENDER, 8'h00, 10'd0, 1'b0);
      offer_item(ACT_RENDER, 8'hFF, 10'd0, 1'b0);
      offer_item(ACT_RENDER, CH_UPPER_A - 8'd1, 10'd0, 1'b0);
      offer_item(ACT_RENDER, CH_UPPER_Z + 8'd1, 10'd0, 1'b0);
      offer_item(ACT_RENDER, CH_LOWER_A - 8'd1, 10'd0, 1'b0);
      offer_item(ACT_RENDER, CH_LOWER_Z + 8'd1, 10'd0, 1'b0);
      offer_item(ACT_READ, 8'h00, 10'd1, 1'b1);
      offer_item(ACT_READ, 8'h00, 10'h3FF, 1'b1);

      // Zero width wraps every glyph; a page count above the maximum
      // saturates on clear.
      wait_drained();
      write_regs(1'b1, 8'd0, 1'b1, 8'h0F);
      offer_item(ACT_CLEAR, 8'h00, 10'd0, 1'b1);
      offer_item(ACT_RENDER, CH_UPPER_A + 8'd12, 10'd0, 1'b1);
      offer_item(ACT_RENDER, CH_LOWER_A + 8'd22, 10'd0, 1'b1);
      offer_item(ACT_RENDER, CH_SPACE, 10'd0, 1'b1);
      offer_item(ACT_READ, 8'h00, 10'd0, 1'b1);

      // Random phases. Each starts from an idle block with one or both registers
      // rewritten; the first is a long run of plain text at full width so the
      // cursor walks past the bottom of the store and writes get dropped.
      first_phase = 1'b1;
      while (items_sent < ITEM_TARGET) begin
         wait_drained();
         if (first_phase) begin
            write_regs(1'b1, 8'd128, 1'b1, 8'd1);
            tidy      = 1'b1;
            phase_len = 360;
         end else begin
            case ($urandom_range(0, 9))
               0:       width_val = 8'd0;
               1:       width_val = 8'd1;
               2:       width_val = 8'($urandom_range(2, 12));
               3:       width_val = 8'd128;
               4:       width_val = 8'd255;
               5:       width_val = 8'd127;
               default: width_val = 8'($urandom_range(13, 255));
            endcase
            // upper nibble of the page write is noise
            pages_val = 8'($urandom_range(0, 255));
            case ($urandom_range(0, 3))
               0:       pages_val[3:0] = 4'd0;
               1:       pages_val[3:0] = 4'd8;
               default: ;
            endcase
            pick = $urandom_range(0, 3);
            write_regs(pick != 2, width_val, pick != 1, pages_val);
            tidy      = ($urandom_range(0, 3) == 0);
            phase_len = ($urandom_range(0, 3) == 0) ? $urandom_range(250, 350)
                                                     : $urandom_range(20, 120);
         end
         gappy = ($urandom_range(0, 9) < 7);
         if (first_phase || $urandom_range(0, 3) != 0) begin
            offer_item(ACT_CLEAR, 8'($urandom_range(0, 255)), 10'($urandom_range(0, 1023)),
                       1'b1);
         end
         first_phase = 1'b0;

         // once in the tail, the phase runs on to the end without a pause
         for (int k = 0; (k < phase_len || items_sent >= ITEM_TARGET - QUIET_TAIL)
                         && items_sent < ITEM_TARGET; k++) begin
            quiet = (items_sent >= ITEM_TARGET - QUIET_TAIL);
            pick  = $urandom_range(0, 99);
            ch    = 8'($urandom_range(0, 255));
            addr  = 10'($urandom_range(0, 1023));
            if (pick < 12) begin
               // half the reads land in the first two pages where text sits
               if (pick[0]) addr[9:8] = 2'b00;
               offer_item(ACT_READ, ch, addr, 1'b1);
            end else if (!tidy && pick < 13) begin
               offer_item(ACT_CLEAR, ch, addr, 1'b1);
            end else if (!tidy && pick < 16) begin
               offer_item(ACT_NONE, ch, addr, 1'b1);
            end else if (!tidy && pick < 24) begin
               // any code; mostly ones the block skips
               offer_item(ACT_RENDER, ch, addr, 1'b0);
            end else begin
               case ($urandom_range(0, 19))
                  0, 1, 2, 3, 4, 5:  ch = CH_UPPER_A + 8'($urandom_range(0, 25));
                  6, 7, 8, 9, 10:    ch = CH_LOWER_A + 8'($urandom_range(0, 25));
                  11, 12, 13, 14:    ch = CH_SPACE;
                  15:                ch = CH_PERIOD;
                  16:                ch = CH_QUESTION;
                  17:                ch = CH_EXCLAIM;
                  default:           ch = CH_COMMA;
               endcase
               offer_item(ACT_RENDER, ch, addr, 1'b1);
            end
         end
      end

      // Let every result come home, then give a stray one time to show up.
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // Hang guard: far beyond the slowest legal run of this stimulus.
   initial begin
      #(20_000_000);
      $display("TEST FAILED");
      $finish;
   end

endmodule
